>>> src/htsa_pkg.sv
// shared types and constants for the hole table allocator
package htsa_pkg;

  localparam int MaxHoles  = 64;
  localparam int AddrBits  = 20;
  localparam int SizeBits  = AddrBits + 1;
  localparam int IdxBits   = $clog2(MaxHoles);
  localparam int CntBits   = IdxBits + 1;
  localparam int EntryBits = AddrBits + SizeBits;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_MEM_SIZE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_DECIDE,
    S_FIX_RD,
    S_FIX,
    S_SHL_RD,
    S_SHL,
    S_SHR_RD,
    S_SHR,
    S_DONE
  } state_t;

endpackage

>>> src/hole_table_segment_allocator.sv
// hole table allocator top level: sequencer, table memory and result register
//
//  channel | ports                      | content (low bits first)
//  in      | in_tvalid/in_tready/tdata  | op[1:0] request_size[22:2] region_base[42:23]
//  out     | out_tvalid/tready/tdata    | status[1:0] alloc_base[21:2] enough_total[22]
//          |                            | free_total[43:23]
//  cfg     | cfg_we/cfg_index/cfg_data  | 0 fit_mode, 1 memory_size
//
// an alloc walks the whole hole table and a free walks it up to the insert
// point, both through the single memory read port, then entries are shifted
// on insert or removal; query requests skip the walk
// reset writes entry 0 while held and a memory_size write reinitializes the
// table: only the hole count and entry 0 change, the contents of entries
// above the count are never used
// in_tready is low from acceptance until the result moves into the output
// register; a stalled output holds the block in its done state
module hole_table_segment_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op, request_size, region_base
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status, alloc_base, enough_total, free_total
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data
);

  localparam int AW = htsa_pkg::AddrBits;
  localparam int SW = htsa_pkg::SizeBits;
  localparam int IW = htsa_pkg::IdxBits;
  localparam int CW = htsa_pkg::CntBits;
  localparam int EW = htsa_pkg::EntryBits;

  htsa_pkg::state_t state_r, state_nxt;
  htsa_pkg::state_t fix_next;

  logic          fit_r, fit_nxt;
  logic [SW-1:0] usize_r, usize_nxt;     // usable memory size
  logic [CW-1:0] cnt_r, cnt_nxt;         // hole count
  logic [SW-1:0] free_r, free_nxt;       // free bytes
  logic [1:0]    op_r, op_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [CW-1:0] idx_r, idx_nxt;         // scan / shift pointer
  logic [CW-1:0] pick_r, pick_nxt;       // best hole, or insert position
  logic          found_r, found_nxt;
  logic [SW-1:0] psize_r, psize_nxt;     // picked hole size
  logic [AW-1:0] pbase_r, pbase_nxt;
  logic [AW:0]   pend_r, pend_nxt;       // end of hole before insert point
  logic          haspre_r, haspre_nxt;
  logic [AW-1:0] nbase_r, nbase_nxt;     // hole at insert point
  logic [SW-1:0] nsize_r, nsize_nxt;
  logic [EW-1:0] hold_r, hold_nxt;       // entry carried by right shift
  logic [1:0]    stat_r, stat_nxt;
  logic [AW-1:0] abase_r, abase_nxt;

  logic          ovld_r, ovld_nxt;
  logic [47:0]   odata_r, odata_nxt;

  // table memory interface
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [AW-1:0] rd_base;
  logic [SW-1:0] rd_size;

  assign rd_base = rdata[AW-1:0];
  assign rd_size = rdata[EW-1:AW];

  htsa_ram #(.Width(EW), .Depth(htsa_pkg::MaxHoles)) u_tbl (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic [AW+1:0] fend;   // end of region being freed, carry kept
  assign fend = {2'b0, base_r} + {1'b0, size_r};

  assign in_tready  = (state_r == htsa_pkg::S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      htsa_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = htsa_pkg::S_SCAN_RD;
        end
      end
      htsa_pkg::S_SCAN_RD: begin
        if (idx_r >= cnt_r) begin
          state_nxt = htsa_pkg::S_DECIDE;
        end else if (op_r == htsa_pkg::OP_FREE && !found_r) begin
          state_nxt = htsa_pkg::S_SCAN;
        end else if (op_r == htsa_pkg::OP_ALLOC) begin
          state_nxt = htsa_pkg::S_SCAN;
        end else begin
          state_nxt = htsa_pkg::S_DECIDE;
        end
      end
      htsa_pkg::S_SCAN:   state_nxt = htsa_pkg::S_SCAN_RD;
      htsa_pkg::S_DECIDE: state_nxt = htsa_pkg::S_FIX_RD;
      htsa_pkg::S_FIX_RD: state_nxt = htsa_pkg::S_FIX;
      htsa_pkg::S_FIX:    state_nxt = state_r;
      htsa_pkg::S_SHL_RD: begin
        if (idx_r + 1'b1 >= cnt_r) begin
          state_nxt = htsa_pkg::S_DONE;
        end else begin
          state_nxt = htsa_pkg::S_SHL;
        end
      end
      htsa_pkg::S_SHL:    state_nxt = htsa_pkg::S_SHL_RD;
      htsa_pkg::S_SHR_RD: begin
        if (idx_r >= cnt_r) begin
          state_nxt = htsa_pkg::S_DONE;
        end else begin
          state_nxt = htsa_pkg::S_SHR;
        end
      end
      htsa_pkg::S_SHR:    state_nxt = htsa_pkg::S_SHR_RD;
      htsa_pkg::S_DONE: begin
        if (!ovld_r || out_tready) begin
          state_nxt = htsa_pkg::S_IDLE;
        end
      end
      default:            state_nxt = htsa_pkg::S_IDLE;
    endcase
    // decide and fix steps choose their own successor
    // a zero-size free turns into a query here and skips the table update
    if (state_r == htsa_pkg::S_DECIDE && stat_nxt != htsa_pkg::ST_OK) begin
      state_nxt = htsa_pkg::S_DONE;
    end
    if (state_r == htsa_pkg::S_DECIDE && stat_nxt == htsa_pkg::ST_OK &&
        op_nxt != htsa_pkg::OP_ALLOC && op_nxt != htsa_pkg::OP_FREE) begin
      state_nxt = htsa_pkg::S_DONE;
    end
    if (state_r == htsa_pkg::S_FIX) begin
      state_nxt = fix_next;
    end
  end

  // datapath and memory control
  always_comb begin
    fit_nxt    = fit_r;
    usize_nxt  = usize_r;
    cnt_nxt    = cnt_r;
    free_nxt   = free_r;
    op_nxt     = op_r;
    size_nxt   = size_r;
    base_nxt   = base_r;
    idx_nxt    = idx_r;
    pick_nxt   = pick_r;
    found_nxt  = found_r;
    psize_nxt  = psize_r;
    pbase_nxt  = pbase_r;
    pend_nxt   = pend_r;
    haspre_nxt = haspre_r;
    nbase_nxt  = nbase_r;
    nsize_nxt  = nsize_r;
    hold_nxt   = hold_r;
    stat_nxt   = stat_r;
    abase_nxt  = abase_r;
    ovld_nxt   = ovld_r;
    odata_nxt  = odata_r;
    fix_next   = htsa_pkg::S_DONE;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = idx_r[IW-1:0];

    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      htsa_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tdata[1:0];
          size_nxt   = in_tdata[22:2];
          base_nxt   = in_tdata[42:23];
          idx_nxt    = '0;
          pick_nxt   = '0;
          found_nxt  = 1'b0;
          haspre_nxt = 1'b0;
          stat_nxt   = htsa_pkg::ST_OK;
          abase_nxt  = '0;
        end
      end
      htsa_pkg::S_SCAN: begin
        // one entry per visit: compare against the request
        if (op_r == htsa_pkg::OP_ALLOC) begin
          if (rd_size >= size_r &&
              (!found_r || (!fit_r && rd_size < psize_r) ||
               (fit_r && rd_size > psize_r))) begin
            found_nxt = 1'b1;
            pick_nxt  = idx_r;
            psize_nxt = rd_size;
            pbase_nxt = rd_base;
          end
        end else begin
          if (rd_base <= base_r) begin
            haspre_nxt = 1'b1;
            pend_nxt   = {1'b0, rd_base} + rd_size;
            pick_nxt   = idx_r + 1'b1;
          end else begin
            found_nxt = 1'b1;   // first hole above the region
            nbase_nxt = rd_base;
            nsize_nxt = rd_size;
          end
        end
        idx_nxt = idx_r + 1'b1;
      end
      htsa_pkg::S_DECIDE: begin
        case (op_r)
          htsa_pkg::OP_ALLOC: begin
            if (!found_r) begin
              stat_nxt = (free_r >= size_r) ? htsa_pkg::ST_NO_FIT : htsa_pkg::ST_NO_SPACE;
            end else begin
              abase_nxt = pbase_r;
              free_nxt  = free_r - size_r;
            end
          end
          htsa_pkg::OP_FREE: begin
            if (size_r == '0) begin
              stat_nxt = htsa_pkg::ST_OK;
              op_nxt   = htsa_pkg::OP_QUERY;
            end else if (fend > {1'b0, usize_r}) begin
              stat_nxt = htsa_pkg::ST_NO_SPACE;
            end else if (haspre_r && pend_r > {1'b0, base_r}) begin
              stat_nxt = htsa_pkg::ST_NO_SPACE;
            end else if (found_r && fend > {2'b0, nbase_r}) begin
              stat_nxt = htsa_pkg::ST_NO_SPACE;
            end else if (!(haspre_r && pend_r == {1'b0, base_r}) &&
                         !(found_r && fend == {2'b0, nbase_r}) &&
                         cnt_r >= CW'(htsa_pkg::MaxHoles)) begin
              stat_nxt = htsa_pkg::ST_FULL;
            end else begin
              free_nxt = free_r + size_r;
            end
          end
          default: ;
        endcase
      end
      htsa_pkg::S_FIX_RD: begin
        raddr = (pick_r == '0) ? '0 : IW'(pick_r - 1'b1);
      end
      htsa_pkg::S_FIX: begin
        if (op_r == htsa_pkg::OP_ALLOC) begin
          if (psize_r == size_r) begin
            idx_nxt  = pick_r;
            fix_next = htsa_pkg::S_SHL_RD;
            raddr    = IW'(pick_r + 1'b1);
          end else begin
            we    = 1'b1;
            waddr = pick_r[IW-1:0];
            wdata = {SW'(psize_r - size_r), AW'(pbase_r + size_r[AW-1:0])};
          end
        end else begin
          // free: rdata holds the entry before the insert point
          if (haspre_r && pend_r == {1'b0, base_r}) begin
            we    = 1'b1;
            waddr = IW'(pick_r - 1'b1);
            if (found_r && fend == {2'b0, nbase_r}) begin
              wdata    = {SW'(rd_size + size_r + nsize_r), rd_base};
              idx_nxt  = pick_r;
              raddr    = IW'(pick_r + 1'b1);
              fix_next = htsa_pkg::S_SHL_RD;
            end else begin
              wdata = {SW'(rd_size + size_r), rd_base};
            end
          end else if (found_r && fend == {2'b0, nbase_r}) begin
            we    = 1'b1;
            waddr = pick_r[IW-1:0];
            wdata = {SW'(nsize_r + size_r), base_r};
          end else begin
            // new hole, push the tail up one slot
            hold_nxt = {size_r, base_r};
            idx_nxt  = pick_r;
            raddr    = pick_r[IW-1:0];
            fix_next = htsa_pkg::S_SHR_RD;
          end
        end
      end
      htsa_pkg::S_SHL_RD: begin
        raddr = IW'(idx_r + 1'b1);
        if (idx_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      htsa_pkg::S_SHL: begin
        // entry idx+1 was read, move it down
        we      = 1'b1;
        waddr   = idx_r[IW-1:0];
        wdata   = rdata;
        idx_nxt = idx_r + 1'b1;
        raddr   = IW'(idx_r + 2'd2);
      end
      htsa_pkg::S_SHR_RD: begin
        raddr = idx_r[IW-1:0];
        if (idx_r >= cnt_r) begin
          we      = 1'b1;
          waddr   = idx_r[IW-1:0];
          wdata   = hold_r;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      htsa_pkg::S_SHR: begin
        we       = 1'b1;
        waddr    = idx_r[IW-1:0];
        wdata    = hold_r;
        hold_nxt = rdata;
        idx_nxt  = idx_r + 1'b1;
        raddr    = IW'(idx_r + 1'b1);
      end
      htsa_pkg::S_DONE: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          odata_nxt = {4'b0, free_r, (free_r >= size_r), abase_r, stat_r};
        end
      end
      default: ;
    endcase

    // configuration writes must arrive only while idle; the block does not enforce it
    if (cfg_we) begin
      case (cfg_index)
        htsa_pkg::CFG_FIT_MODE: fit_nxt = cfg_data[0];
        htsa_pkg::CFG_MEM_SIZE: begin
          usize_nxt = (cfg_data > SW'(1 << AW)) ? SW'(1 << AW) : cfg_data;
          free_nxt  = usize_nxt;
          cnt_nxt   = (usize_nxt == '0) ? '0 : CW'(1);
          we        = 1'b1;
          waddr     = '0;
          wdata     = {usize_nxt, AW'(0)};
        end
        default: ;
      endcase
    end

    // entry 0 becomes the single initial hole while reset is held
    if (!rst_n) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {SW'(4096), AW'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= htsa_pkg::S_IDLE;
      fit_r   <= 1'b0;
      usize_r <= SW'(4096);
      cnt_r   <= CW'(1);
      free_r  <= SW'(4096);
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fit_r   <= fit_nxt;
      usize_r <= usize_nxt;
      cnt_r   <= cnt_nxt;
      free_r  <= free_nxt;
      ovld_r  <= ovld_nxt;
    end
    op_r     <= op_nxt;
    size_r   <= size_nxt;
    base_r   <= base_nxt;
    idx_r    <= idx_nxt;
    pick_r   <= pick_nxt;
    found_r  <= found_nxt;
    psize_r  <= psize_nxt;
    pbase_r  <= pbase_nxt;
    pend_r   <= pend_nxt;
    haspre_r <= haspre_nxt;
    nbase_r  <= nbase_nxt;
    nsize_r  <= nsize_nxt;
    hold_r   <= hold_nxt;
    stat_r   <= stat_nxt;
    abase_r  <= abase_nxt;
    odata_r  <= odata_nxt;
  end

  // assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(htsa_pkg::MaxHoles)) else $error("hole count overflow");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= usize_r) else $error("free bytes exceed memory");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("ready during work");

endmodule

>>> src/htsa_ram.sv
// generic single write port ram with registered read
module htsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> dv/tb_hole_table_segment_allocator.sv
// testbench for the hole table allocator: directed and random requests against a local model
`timescale 1ns / 1ps

module tb_hole_table_segment_allocator;

  // predicted result of one request
  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] alloc_base;
    logic        enough_total;
    logic [20:0] free_total;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // op, request_size, region_base
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // status, alloc_base, enough_total, free_total
  logic        cfg_we;
  logic        cfg_index;
  logic [20:0] cfg_data;

  hole_table_segment_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow state of the allocator
  logic        mdl_fit_worst;
  logic [20:0] mdl_mem_size;
  logic [19:0] hole_base[htsa_pkg::MaxHoles];
  logic [20:0] hole_len[htsa_pkg::MaxHoles];
  int          hole_cnt;
  logic [20:0] free_bytes;

  alloc_result_t expected_results[$];
  int  error_count;
  bit  idle_enable;   // when clear, neither side idles
  // allocations handed out, kept so frees can return them
  logic [19:0] owned_base[$];
  logic [20:0] owned_len[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [20:0] usable_bytes();
    return (mdl_mem_size > 21'h100000) ? 21'h100000 : mdl_mem_size;
  endfunction

  function automatic void table_reinit();
    for (int i = 0; i < htsa_pkg::MaxHoles; i++) begin
      hole_base[i] = '0;
      hole_len[i]  = '0;
    end
    hole_len[0] = usable_bytes();
    hole_cnt    = (usable_bytes() != 0) ? 1 : 0;
    free_bytes  = usable_bytes();
  endfunction

  function automatic void drop_hole(int pos);
    for (int i = pos; i + 1 < hole_cnt; i++) begin
      hole_base[i] = hole_base[i + 1];
      hole_len[i]  = hole_len[i + 1];
    end
    hole_cnt--;
    hole_base[hole_cnt] = '0;
    hole_len[hole_cnt]  = '0;
  endfunction

  function automatic logic [1:0] alloc_segment(logic [20:0] len, output logic [19:0] base);
    int pick;
    bit found;
    pick  = 0;
    found = 0;
    base  = '0;
    for (int i = 0; i < hole_cnt; i++) begin
      if (hole_len[i] < len) continue;
      if (!found || (!mdl_fit_worst && hole_len[i] < hole_len[pick]) ||
          (mdl_fit_worst && hole_len[i] > hole_len[pick])) begin
        pick  = i;
        found = 1;
      end
    end
    if (!found) begin
      return (free_bytes >= len) ? htsa_pkg::ST_NO_FIT : htsa_pkg::ST_NO_SPACE;
    end
    base = hole_base[pick];
    if (hole_len[pick] == len) begin
      drop_hole(pick);
    end else begin
      hole_base[pick] += len[19:0];
      hole_len[pick]  -= len;
    end
    free_bytes -= len;
    return htsa_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] free_region(logic [19:0] base, logic [20:0] len);
    int pos;
    logic [21:0] stop;
    bit left, right;
    pos  = 0;
    stop = {2'b0, base} + len;
    if (len == 0) return htsa_pkg::ST_OK;
    if (stop > usable_bytes()) return htsa_pkg::ST_NO_SPACE;
    while (pos < hole_cnt && hole_base[pos] <= base) pos++;
    if (pos > 0 && {2'b0, hole_base[pos - 1]} + hole_len[pos - 1] > base) begin
      return htsa_pkg::ST_NO_SPACE;
    end
    if (pos < hole_cnt && stop > hole_base[pos]) return htsa_pkg::ST_NO_SPACE;
    left  = pos > 0 && {2'b0, hole_base[pos - 1]} + hole_len[pos - 1] == base;
    right = pos < hole_cnt && hole_base[pos] == stop;
    if (left && right) begin
      hole_len[pos - 1] += len + hole_len[pos];
      drop_hole(pos);
    end else if (left) begin
      hole_len[pos - 1] += len;
    end else if (right) begin
      hole_base[pos] = base;
      hole_len[pos] += len;
    end else begin
      if (hole_cnt >= htsa_pkg::MaxHoles) return htsa_pkg::ST_FULL;
      for (int i = hole_cnt; i > pos; i--) begin
        hole_base[i] = hole_base[i - 1];
        hole_len[i]  = hole_len[i - 1];
      end
      hole_base[pos] = base;
      hole_len[pos]  = len;
      hole_cnt++;
    end
    free_bytes += len;
    return htsa_pkg::ST_OK;
  endfunction

  function automatic alloc_result_t predict_request(htsa_pkg::op_t op, logic [20:0] len,
                                                    logic [19:0] base);
    alloc_result_t r;
    logic [19:0] ab;
    r = '0;
    if (op == htsa_pkg::OP_ALLOC) begin
      r.status = alloc_segment(len, ab);
      if (r.status == htsa_pkg::ST_OK) begin
        r.alloc_base = ab;
        owned_base.push_back(ab);
        owned_len.push_back(len);
      end
    end else if (op == htsa_pkg::OP_FREE) begin
      r.status = free_region(base, len);
    end
    r.enough_total = free_bytes >= len;
    r.free_total   = free_bytes;
    return r;
  endfunction

  // one request: random gap, handshake, then predict
  task automatic send_request(htsa_pkg::op_t op, logic [20:0] len, logic [19:0] base);
    while (idle_enable && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, base, len, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(predict_request(op, len, base));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [20:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == htsa_pkg::CFG_FIT_MODE) begin
      mdl_fit_worst = val[0];
    end else begin
      mdl_mem_size = val;
      table_reinit();
      owned_base.delete();
      owned_len.delete();
    end
    @(posedge clk);
  endtask

  // free a previously allocated segment in full, or a random region when none is owned
  task automatic free_owned();
    int k;
    logic [20:0] len;
    if (owned_base.size() == 0) begin
      send_request(htsa_pkg::OP_FREE, 21'($urandom_range(64)), 20'($urandom_range(4095)));
      return;
    end
    k   = $urandom_range(owned_base.size() - 1);
    len = owned_len[k];
    send_request(htsa_pkg::OP_FREE, len, owned_base[k]);
    owned_base.delete(k);
    owned_len.delete(k);
  endtask

  // output side: random stalls and field checks
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      alloc_result_t got, want;
      got = '{out_tdata[1:0], out_tdata[21:2], out_tdata[22], out_tdata[43:23]};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.alloc_base !== want.alloc_base) begin
          $display("%0t: alloc_base exp %h got %h", $time, want.alloc_base, got.alloc_base);
          error_count++;
        end
        if (got.enough_total !== want.enough_total) begin
          $display("%0t: enough_total exp %0d got %0d", $time, want.enough_total,
                   got.enough_total);
          error_count++;
        end
        if (got.free_total !== want.free_total) begin
          $display("%0t: free_total exp %0d got %0d", $time, want.free_total, got.free_total);
          error_count++;
        end
      end
    end
    out_tready <= !idle_enable || ($urandom_range(99) >= 34);
  end

  // field extremes, every op, zero sizes and rejected frees
  task automatic test_directed();
    send_request(htsa_pkg::OP_QUERY, 21'd0, 20'd0);
    send_request(htsa_pkg::OP_RSVD, 21'h1FFFFF, 20'hFFFFF);
    send_request(htsa_pkg::OP_ALLOC, 21'd0, 20'd0);          // zero size on the only hole
    send_request(htsa_pkg::OP_ALLOC, 21'd100, 20'd0);
    send_request(htsa_pkg::OP_ALLOC, 21'd200, 20'd0);
    send_request(htsa_pkg::OP_ALLOC, 21'h1FFFFF, 20'd0);     // no space
    send_request(htsa_pkg::OP_FREE, 21'd0, 20'd50);          // zero free
    send_request(htsa_pkg::OP_FREE, 21'd50, 20'd0);          // leaves a gap
    send_request(htsa_pkg::OP_ALLOC, 21'd3900, 20'd0);       // no space
    send_request(htsa_pkg::OP_FREE, 21'd10, 20'd40);         // overlaps a hole
    send_request(htsa_pkg::OP_FREE, 21'd10, 20'd4090);       // past the end
    send_request(htsa_pkg::OP_FREE, 21'h1FFFFF, 20'hFFFFF);
    send_request(htsa_pkg::OP_FREE, 21'd50, 20'd50);         // merges left
    send_request(htsa_pkg::OP_FREE, 21'd200, 20'd100);       // merges both sides
    send_request(htsa_pkg::OP_QUERY, 21'd4096, 20'd0);
    send_request(htsa_pkg::OP_QUERY, 21'd4097, 20'd0);
    wait_drained();
    // empty memory: zero-size allocate fails
    write_reg(htsa_pkg::CFG_MEM_SIZE, 21'd0);
    send_request(htsa_pkg::OP_ALLOC, 21'd0, 20'd0);
    send_request(htsa_pkg::OP_FREE, 21'd1, 20'd0);
    wait_drained();
    // size above the address range is clipped
    write_reg(htsa_pkg::CFG_MEM_SIZE, 21'h1FFFFF);
    write_reg(htsa_pkg::CFG_FIT_MODE, 21'd1);
    send_request(htsa_pkg::OP_ALLOC, 21'h100000, 20'd0);
    send_request(htsa_pkg::OP_FREE, 21'h100000, 20'd0);
    send_request(htsa_pkg::OP_FREE, 21'h1, 20'hFFFFF);
    wait_drained();
  endtask

  // fill the table with small holes until a free hits the entry limit
  task automatic test_table_full();
    write_reg(htsa_pkg::CFG_FIT_MODE, 21'd0);
    write_reg(htsa_pkg::CFG_MEM_SIZE, 21'd1024);
    for (int i = 0; i < 70; i++) send_request(htsa_pkg::OP_ALLOC, 21'd8, 20'd0);
    for (int i = 0; i < 70; i++) send_request(htsa_pkg::OP_FREE, 21'd4, 20'(i * 8));
    for (int i = 0; i < 8; i++) send_request(htsa_pkg::OP_ALLOC, 21'd4, 20'd0);
    wait_drained();
  endtask

  // mostly allocate/free pairs of owned segments, with some noise
  task automatic test_random(int n, logic fit, logic [20:0] msize);
    int pick;
    write_reg(htsa_pkg::CFG_FIT_MODE, {20'b0, fit});
    write_reg(htsa_pkg::CFG_MEM_SIZE, msize);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();   // hold off until all results are in
      idle_enable = !(i >= n / 4 && i < n / 4 + 60);
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_request(htsa_pkg::OP_ALLOC, ($urandom_range(9) == 0) ? 21'($urandom)
                     : 21'($urandom_range(msize / 16 + 1)), 20'($urandom));
      end else if (pick < 85) begin
        free_owned();
      end else if (pick < 93) begin
        send_request(htsa_pkg::op_t'($urandom_range(3)), 21'($urandom), 20'($urandom));
      end else begin
        send_request(htsa_pkg::OP_FREE, 21'($urandom_range(32)), 20'($urandom_range(msize)));
      end
    end
    idle_enable = 1'b1;
    wait_drained();
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = 1'b0;
    cfg_data    = '0;
    error_count = 0;
    idle_enable = 1'b1;
    mdl_fit_worst = 1'b0;
    mdl_mem_size  = 21'd4096;
    table_reinit();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(400, 1'b0, 21'd4096);
    test_random(400, 1'b1, 21'd4096);
    test_random(300, 1'b0, 21'h100000);
    test_random(300, 1'b1, 21'd1);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
